@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/hcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Chunked decoder package
// Result codes, character constants, queue entry type and byte classifiers.
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int TotalW     = 32;
  localparam int LogRadix   = 4;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharHighX = 8'h58;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic              has_payload;
    logic [7:0]        payload_byte;
    logic              has_final;
    kind_e             final_kind;
    logic [TotalW-1:0] total_size;
  } entry_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

@@ hw/rtl/hcd_in_if.sv @@
// ----------------------------------------------------------------------------
// Chunked decoder input channel
// Valid/ready channel carrying one raw message byte per transfer.
// ----------------------------------------------------------------------------
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source(output valid, output data_byte, output end_of_message, input ready);
  modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ hw/rtl/hcd_out_if.sv @@
// ----------------------------------------------------------------------------
// Chunked decoder output channel
// Valid/ready channel carrying one decoded result per transfer.
// ----------------------------------------------------------------------------
interface hcd_out_if;
  logic                          valid;
  logic                          ready;
  hcd_pkg::kind_e                kind;
  logic [7:0]                    payload_byte;
  logic [hcd_pkg::TotalW-1:0]    total_size;
  logic                          final_result;

  modport source(output valid, output kind, output payload_byte, output total_size,
                 output final_result, input ready);
  modport sink(input valid, input kind, input payload_byte, input total_size,
               input final_result, output ready);
endinterface

@@ hw/rtl/hcd_front.sv @@
// ----------------------------------------------------------------------------
// Chunked decoder front end
// Parses size lines, tracks chunk payload and CR LF, queues result entries.
// ----------------------------------------------------------------------------
module hcd_front #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcd_in_if.sink          in_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output hcd_pkg::entry_t entry_o
);

  localparam int SB   = SIZE_BITS;
  localparam int ExtW = (SB > hcd_pkg::TotalW) ? SB : hcd_pkg::TotalW;

  typedef enum logic [3:0] {
    PH_SIZE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  typedef enum logic [5:0] {
    SC_START  = 6'b000001,
    SC_ZERO   = 6'b000010,
    SC_PREFIX = 6'b000100,
    SC_DIGITS = 6'b001000,
    SC_AFTER  = 6'b010000,
    SC_BAD    = 6'b100000
  } scan_e;

  phase_e        phase_q, phase_d;
  scan_e         scan_q, scan_d, scan_n;
  logic [7:0]    prev_q, prev_d;
  logic [SB-1:0] size_q, size_d, size_n, size_acc;
  logic [SB-1:0] left_q, left_d, left_n;
  logic [SB-1:0] total_q, total_d;
  logic [SB:0]   total_sum;
  logic [ExtW-1:0]           total_ext;
  logic [hcd_pkg::TotalW-1:0] total_sat;

  logic [7:0] c;
  logic       eom;
  logic       accept;
  logic [4:0] hex;
  logic       have_digit;
  logic       crlf;
  logic       emit_pay;
  logic       emit_fin;
  hcd_pkg::kind_e fin_kind;

  assign c         = in_i.data_byte;
  assign eom       = in_i.end_of_message;
  assign in_i.ready = q_ready_i;
  assign accept    = in_i.valid && q_ready_i;
  assign hex       = hcd_pkg::hex_digit(c);
  assign crlf      = (prev_q == hcd_pkg::CharCr) && (c == hcd_pkg::CharLf);

  // saturate on overflow of the shifted size
  assign size_acc = (size_q[SB-1 -: hcd_pkg::LogRadix] != '0) ? '1
                  : {size_q[SB-hcd_pkg::LogRadix-1:0], hex[3:0]};

  assign total_sum = {1'b0, total_q} + {1'b0, size_n};
  assign left_n    = (left_q != '0) ? left_q - SB'(1) : left_q;
  assign total_ext = ExtW'(total_q);
  assign total_sat = (total_ext > ExtW'({hcd_pkg::TotalW{1'b1}})) ? '1
                   : total_ext[hcd_pkg::TotalW-1:0];

  always_comb begin
    scan_n = scan_q;
    size_n = size_q;
    unique case (scan_q) inside
      SC_START: begin
        if (c == hcd_pkg::CharZero) begin
          scan_n = SC_ZERO;
        end else if (hex[4]) begin
          size_n = size_acc;
          scan_n = SC_DIGITS;
        end else if (!hcd_pkg::is_space(c)) begin
          scan_n = SC_BAD;
        end
      end
      SC_ZERO: begin
        if (c == hcd_pkg::CharLowX || c == hcd_pkg::CharHighX) begin
          scan_n = SC_PREFIX;
        end else if (hex[4]) begin
          size_n = size_acc;
          scan_n = SC_DIGITS;
        end else begin
          scan_n = SC_AFTER;
        end
      end
      SC_PREFIX, SC_DIGITS: begin
        if (hex[4]) begin
          size_n = size_acc;
          scan_n = SC_DIGITS;
        end else begin
          scan_n = SC_AFTER;
        end
      end
      default: begin
        scan_n = scan_q;
      end
    endcase
  end

  assign have_digit = (scan_n == SC_ZERO) || (scan_n == SC_PREFIX) ||
                      (scan_n == SC_DIGITS) || (scan_n == SC_AFTER);

  always_comb begin
    phase_d  = phase_q;
    scan_d   = scan_q;
    prev_d   = prev_q;
    size_d   = size_q;
    left_d   = left_q;
    total_d  = total_q;
    emit_pay = 1'b0;
    emit_fin = 1'b0;
    fin_kind = hcd_pkg::KIND_ERROR;

    unique case (phase_q)
      PH_SIZE: begin
        scan_d = scan_n;
        size_d = size_n;
        if (crlf) begin
          if (!have_digit) begin
            emit_fin = 1'b1;
          end else if (size_n == '0) begin
            emit_fin = 1'b1;
            fin_kind = hcd_pkg::KIND_DONE;
          end else begin
            total_d = total_sum[SB] ? '1 : total_sum[SB-1:0];
            left_d  = size_n;
            phase_d = PH_DATA;
            emit_fin = eom;
          end
        end else if (eom) begin
          emit_fin = 1'b1;
          if (have_digit && size_n == '0) begin
            fin_kind = hcd_pkg::KIND_DONE;
          end
        end else begin
          prev_d = c;
        end
      end
      PH_DATA: begin
        emit_pay = 1'b1;
        left_d   = left_n;
        if (left_n == '0) begin
          phase_d = PH_SKIP;
          prev_d  = '0;
        end
        emit_fin = eom;
      end
      PH_SKIP: begin
        if (eom) begin
          emit_fin = 1'b1;
        end else if (crlf) begin
          phase_d = PH_SIZE;
          prev_d  = '0;
          size_d  = '0;
          scan_d  = SC_START;
        end else begin
          prev_d = c;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (eom) begin
      phase_d = PH_SIZE;
      scan_d  = SC_START;
      prev_d  = '0;
      size_d  = '0;
      left_d  = '0;
      total_d = '0;
    end else if (emit_fin) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      scan_q  <= SC_START;
      prev_q  <= '0;
      size_q  <= '0;
      left_q  <= '0;
      total_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      scan_q  <= scan_d;
      prev_q  <= prev_d;
      size_q  <= size_d;
      left_q  <= left_d;
      total_q <= total_d;
    end
  end

  assign push_o               = accept && (emit_pay || emit_fin);
  assign entry_o.has_payload  = emit_pay;
  assign entry_o.payload_byte = c;
  assign entry_o.has_final    = emit_fin;
  assign entry_o.final_kind   = fin_kind;
  assign entry_o.total_size   = (fin_kind == hcd_pkg::KIND_DONE) ? total_sat : '0;

endmodule

@@ hw/rtl/hcd_queue.sv @@
// ----------------------------------------------------------------------------
// Chunked decoder entry queue
// Small register FIFO between front end and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcd_pkg::entry_t entry_i,
  output logic            ready_o,
  output logic            valid_o,
  output hcd_pkg::entry_t entry_o,
  input  logic            pop_i
);

  hcd_pkg::entry_t                 mem_q [hcd_pkg::QueueDepth];
  logic [hcd_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hcd_pkg::QueueCntW-1:0]   count_q;

  assign ready_o = (count_q != hcd_pkg::QueueCntW'(hcd_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + hcd_pkg::QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + hcd_pkg::QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + hcd_pkg::QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - hcd_pkg::QueueCntW'(1);
      end
    end
  end

  `ASSERT_NEVER(q_no_overflow, clk_i, rst_ni, push_i && !ready_o)
  `ASSERT_NEVER(q_no_underflow, clk_i, rst_ni, pop_i && !valid_o)

endmodule

@@ hw/rtl/hcd_back.sv @@
// ----------------------------------------------------------------------------
// Chunked decoder output stage
// Expands queue entries into result transfers through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  hcd_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  hcd_out_if.source       out_o
);

  logic            out_valid_q, out_valid_d;
  hcd_pkg::kind_e  kind_q, kind_d;
  logic [7:0]      byte_q, byte_d;
  logic [hcd_pkg::TotalW-1:0] total_q, total_d;
  logic            final_q, final_d;
  logic            pend_q, pend_d;
  hcd_pkg::entry_t pend_entry_q, pend_entry_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_o.ready;
  assign q_pop_o   = slot_free && !pend_q && q_valid_i;

  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    kind_d       = kind_q;
    byte_d       = byte_q;
    total_d      = total_q;
    final_d      = final_q;
    pend_d       = pend_q;
    pend_entry_d = pend_entry_q;
    if (slot_free) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        kind_d      = pend_entry_q.final_kind;
        byte_d      = '0;
        total_d     = pend_entry_q.total_size;
        final_d     = 1'b1;
        pend_d      = 1'b0;
      end else if (q_valid_i) begin
        out_valid_d = 1'b1;
        if (q_entry_i.has_payload) begin
          kind_d       = hcd_pkg::KIND_PAYLOAD;
          byte_d       = q_entry_i.payload_byte;
          total_d      = '0;
          final_d      = 1'b0;
          pend_d       = q_entry_i.has_final;
          pend_entry_d = q_entry_i;
        end else begin
          kind_d  = q_entry_i.final_kind;
          byte_d  = '0;
          total_d = q_entry_i.total_size;
          final_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    byte_q       <= byte_d;
    total_q      <= total_d;
    final_q      <= final_d;
    pend_entry_q <= pend_entry_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.payload_byte = byte_q;
  assign out_o.total_size   = total_q;
  assign out_o.final_result = final_q;

  `ASSERT_PROP(back_pend_has_out, clk_i, rst_ni, pend_q |-> out_valid_q)
  `ASSERT_PROP(back_pend_after_payload, clk_i, rst_ni, pend_q |-> kind_q == hcd_pkg::KIND_PAYLOAD)

endmodule

@@ hw/rtl/http_chunked_decoder.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Input channel in_i: one raw body byte per transfer, end_of_message set on
// the last byte of a message. Output channel out_o: one result per transfer,
// kind payload (a decoded payload byte), done (total_size holds the sum of
// chunk sizes, saturated) or error; final_result marks done and error.
// One input byte is taken every cycle while the entry queue has room; the
// parser updates its line and chunk state as each byte is accepted.
// Each result passes through the queue and then the output register. A
// byte yields at most two results (payload then error on a truncated
// chunk), which leave as two separate output transfers.
// When the receiver stalls, results wait in the output register and the
// 4-entry queue; input ready drops once the queue is full.
// Reset clears the parser to the start of a size line and empties the
// queue and output stage; no result is pending after reset.
// ----------------------------------------------------------------------------
module http_chunked_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcd_in_if.sink    in_i,
  hcd_out_if.source out_o
);

  logic            push;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;
  hcd_pkg::entry_t push_entry;
  hcd_pkg::entry_t head_entry;

  hcd_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_ready_i(q_ready),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  hcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .entry_o(head_entry),
    .pop_i  (q_pop)
  );

  hcd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_entry_i(head_entry),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

endmodule

@@ bench/http_chunked_decoder_test.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked decoder testbench
// Sends chunked messages one byte per transfer and checks every result
// against a local decoder model of the size-line, payload and CR LF phases.
// Directed cases cover size-line forms, errors, early ends and ignored tails.
// Random messages follow, mostly well formed, some truncated, corrupted or
// replaced by noise. Both channels idle at random, with a long hold-off on
// the output side.
// ----------------------------------------------------------------------------
module http_chunked_decoder_test;

  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 10;
  localparam logic [31:0] SizeMax = '1;

  typedef enum logic [1:0] {
    PH_SIZE_LINE,
    PH_PAYLOAD,
    PH_SKIP_CRLF,
    PH_FINISHED
  } phase_e;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_ZERO,
    SCAN_PREFIX,
    SCAN_DIGITS,
    SCAN_AFTER,
    SCAN_BAD
  } scan_e;

  typedef struct packed {
    hcd_pkg::kind_e kind;
    logic [7:0]     payload_byte;
    logic [31:0]    total_size;
    logic           final_result;
  } chunk_result_t;

  logic clk_i;
  logic rst_ni;

  hcd_in_if  in_if ();
  hcd_out_if out_if ();

  http_chunked_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  chunk_result_t expected_results[$];
  logic [7:0]    msg_q[$];
  int            mismatch_count;
  int            idle_cycles;
  int            hold_left;
  bit            quiet;

  phase_e      ph;
  logic [7:0]  prev_char;
  logic [31:0] size_acc;
  scan_e       scan;
  logic [31:0] remaining;
  logic [31:0] size_sum;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Decoder model

  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return 16;
  endfunction

  function automatic void step_digit(int d);
    if (size_acc > (SizeMax - 32'(d)) / 16) begin
      size_acc = SizeMax;
    end else begin
      size_acc = size_acc * 16 + 32'(d);
    end
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int d;
    d = digit_of(c);
    case (scan)
      SCAN_START: begin
        if (c == hcd_pkg::CharZero) begin
          scan = SCAN_ZERO;
        end else if (d < 16) begin
          step_digit(d);
          scan = SCAN_DIGITS;
        end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
          scan = SCAN_BAD;
        end
      end
      SCAN_ZERO: begin
        if (c == hcd_pkg::CharLowX || c == hcd_pkg::CharHighX) begin
          scan = SCAN_PREFIX;
        end else if (d < 16) begin
          step_digit(d);
          scan = SCAN_DIGITS;
        end else begin
          scan = SCAN_AFTER;
        end
      end
      SCAN_PREFIX, SCAN_DIGITS: begin
        if (d < 16) begin
          step_digit(d);
          scan = SCAN_DIGITS;
        end else begin
          scan = SCAN_AFTER;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void start_line();
    ph        = PH_SIZE_LINE;
    prev_char = 8'h00;
    size_acc  = '0;
    scan      = SCAN_START;
  endfunction

  function automatic void reset_decoder();
    start_line();
    remaining = '0;
    size_sum  = '0;
  endfunction

  function automatic void add_expected(hcd_pkg::kind_e k, logic [7:0] pb, logic [31:0] total);
    chunk_result_t r;
    r.kind         = k;
    r.payload_byte = pb;
    r.total_size   = total;
    r.final_result = (k != hcd_pkg::KIND_PAYLOAD);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic eom);
    logic        fin;
    logic        has_digit;
    logic [32:0] sum_wide;
    fin = 1'b0;
    case (ph)
      PH_SIZE_LINE: begin
        scan_char(c);
        has_digit = scan inside {SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS, SCAN_AFTER};
        if (prev_char == hcd_pkg::CharCr && c == hcd_pkg::CharLf) begin
          if (!has_digit) begin
            add_expected(hcd_pkg::KIND_ERROR, 8'h00, '0);
            fin = 1'b1;
          end else if (size_acc == 0) begin
            add_expected(hcd_pkg::KIND_DONE, 8'h00, size_sum);
            fin = 1'b1;
          end else begin
            sum_wide  = size_sum + size_acc;
            size_sum  = sum_wide[32] ? SizeMax : sum_wide[31:0];
            remaining = size_acc;
            ph        = PH_PAYLOAD;
            if (eom) begin
              add_expected(hcd_pkg::KIND_ERROR, 8'h00, '0);
              fin = 1'b1;
            end
          end
        end else if (eom) begin
          if (has_digit && size_acc == 0) begin
            add_expected(hcd_pkg::KIND_DONE, 8'h00, size_sum);
          end else begin
            add_expected(hcd_pkg::KIND_ERROR, 8'h00, '0);
          end
          fin = 1'b1;
        end else begin
          prev_char = c;
        end
      end
      PH_PAYLOAD: begin
        add_expected(hcd_pkg::KIND_PAYLOAD, c, '0);
        if (remaining > 0) remaining = remaining - 1;
        if (remaining == 0) begin
          ph        = PH_SKIP_CRLF;
          prev_char = 8'h00;
        end
        if (eom) begin
          add_expected(hcd_pkg::KIND_ERROR, 8'h00, '0);
          fin = 1'b1;
        end
      end
      PH_SKIP_CRLF: begin
        if (eom) begin
          add_expected(hcd_pkg::KIND_ERROR, 8'h00, '0);
          fin = 1'b1;
        end else if (prev_char == hcd_pkg::CharCr && c == hcd_pkg::CharLf) begin
          start_line();
        end else begin
          prev_char = c;
        end
      end
      default: ;
    endcase
    if (eom) begin
      reset_decoder();
    end else if (fin) begin
      ph = PH_FINISHED;
    end
  endfunction

  // Monitor and watchdog

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin
    chunk_result_t want;
    logic          in_xfer;
    logic          out_xfer;
    in_xfer  = rst_ni && in_if.valid && in_if.ready;
    out_xfer = rst_ni && out_if.valid && out_if.ready;
    if (out_xfer) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d byte=%02h total=%08h final=%0b",
                                out_if.kind, out_if.payload_byte, out_if.total_size,
                                out_if.final_result));
      end else begin
        want = expected_results.pop_front();
        if (out_if.kind !== want.kind || out_if.payload_byte !== want.payload_byte ||
            out_if.total_size !== want.total_size ||
            out_if.final_result !== want.final_result) begin
          flag_mismatch($sformatf(
              "expected kind=%0d byte=%02h total=%08h final=%0b, got %0d %02h %08h %0b",
              want.kind, want.payload_byte, want.total_size, want.final_result,
              out_if.kind, out_if.payload_byte, out_if.total_size, out_if.final_result));
        end
      end
    end
    if (in_xfer) decode_byte(in_if.data_byte, in_if.end_of_message);
    if (in_xfer || out_xfer) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // Sender

  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (!quiet) begin
      while ($urandom_range(99) < 23) begin
        in_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= b;
    in_if.end_of_message <= eom;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
    end
    msg_q.delete();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Message building

  function automatic void put_byte(logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    put_byte(hcd_pkg::CharCr);
    put_byte(hcd_pkg::CharLf);
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == hcd_pkg::CharCr) ? 8'h2e : b;
  endfunction

  function automatic void add_payload(int n);
    repeat (n) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void add_size_line(int unsigned n);
    logic [3:0] nib;
    bit         lead;
    lead = 1'b1;
    repeat ($urandom_range(2, 0)) begin
      case ($urandom_range(3))
        0: put_byte(8'h20);
        1: put_byte(8'h09);
        2: put_byte(8'h0b);
        default: put_byte(8'h0c);
      endcase
    end
    case ($urandom_range(3))
      0: begin
        put_byte(hcd_pkg::CharZero);
        put_byte($urandom_range(1) ? hcd_pkg::CharLowX : hcd_pkg::CharHighX);
      end
      1: repeat ($urandom_range(2, 1)) put_byte(hcd_pkg::CharZero);
      default: ;
    endcase
    for (int sh = 28; sh >= 0; sh -= 4) begin
      nib = 4'(n >> sh);
      if (nib != 0 || !lead || sh == 0) begin
        lead = 1'b0;
        if (nib < 10) begin
          put_byte(hcd_pkg::CharZero + 8'(nib));
        end else begin
          put_byte(($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
        end
      end
    end
    if ($urandom_range(3) == 0) begin
      add_text(";");
      repeat ($urandom_range(5, 0)) put_byte(rand_text_byte());
    end
    add_crlf();
  endfunction

  // Tests

  task automatic test_chunk_basics();
    add_text("3;ext=1"); add_crlf(); add_text("abc"); add_crlf();
    add_text("0Xa"); add_crlf();
    put_byte(8'h00); put_byte(8'hff); add_text("01234567");
    add_text("junk"); add_crlf(); add_text("0"); add_crlf(); add_crlf();
    send_message();
  endtask

  task automatic test_size_line_forms();
    add_text(" \t0x1;x"); add_crlf(); add_text("Z"); add_crlf();
    add_text("0x"); add_crlf();
    send_message();
    add_text("0Xg"); add_crlf();
    send_message();
    add_text("0");
    send_message();
    add_text("0x");
    send_message();
    add_text(" 0;e");
    send_message();
    add_text(" \t");
    send_message();
    add_crlf();
    send_message();
    add_text("+5"); add_crlf();
    send_message();
    add_text("-1"); add_crlf();
    send_message();
  endtask

  task automatic test_early_end();
    add_text("1"); add_crlf(); add_text("q");
    send_message();
    add_text("1"); add_crlf(); add_text("qZ");
    send_message();
    add_text("5");
    send_message();
    add_text("2"); add_crlf();
    send_message();
    add_text("1FFFFFFFF0"); add_crlf(); add_payload(3);
    send_message();
  endtask

  task automatic test_ignored_tail();
    add_text("0"); add_crlf(); add_text("abc");
    send_message();
    add_text("G"); add_crlf(); add_text("1"); add_crlf();
    send_message();
    wait_drained();
  endtask

  task automatic test_back_pressure();
    @(posedge clk_i);
    hold_left = 60;
    @(negedge clk_i);
    add_size_line(30); add_payload(30); add_crlf(); add_size_line(0);
    send_message();
    wait_drained();
  endtask

  task automatic test_random_messages();
    int sent;
    int n;
    sent = 0;
    while (sent < 340) begin
      quiet = (sent < 80);
      repeat ($urandom_range(3, 0)) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        add_size_line(n);
        add_payload(n);
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(4, 1)) put_byte(rand_text_byte());
        end
        add_crlf();
      end
      add_size_line(0);
      if ($urandom_range(1)) add_crlf();
      case ($urandom_range(9))
        0: repeat ($urandom_range(msg_q.size() - 1)) void'(msg_q.pop_back());
        1: msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
        2: begin
          msg_q.delete();
          repeat ($urandom_range(12, 1)) put_byte(8'($urandom_range(255)));
        end
        default: ;
      endcase
      sent += msg_q.size();
      send_message();
    end
    quiet = 1'b0;
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = 8'h00;
    in_if.end_of_message = 1'b0;
    out_if.ready         = 1'b0;
    quiet                = 1'b0;
    hold_left            = 0;
    mismatch_count       = 0;
    idle_cycles          = 0;
    reset_decoder();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_chunk_basics();
    test_size_line_forms();
    test_early_end();
    test_ignored_tail();
    test_back_pressure();
    test_random_messages();
    finish_run();
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_in_if.sv
hw/rtl/hcd_out_if.sv
hw/rtl/hcd_front.sv
hw/rtl/hcd_queue.sv
hw/rtl/hcd_back.sv
hw/rtl/http_chunked_decoder.sv
bench/http_chunked_decoder_test.sv
